// ===== hw/rtl/scf_pkg.sv =====
package scf_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_VIS_W  = 3'd0;
    localparam logic [2:0] REG_VIS_H  = 3'd1;
    localparam logic [2:0] REG_MAX_X  = 3'd2;
    localparam logic [2:0] REG_MAX_Y  = 3'd3;
    localparam logic [2:0] REG_BUF_W  = 3'd4;
    localparam logic [2:0] REG_BUF_H  = 3'd5;
    localparam logic [2:0] REG_STEP   = 3'd6;

    // Opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // Register reset values
    localparam logic [9:0]  RST_VIS_W = 10'd256;
    localparam logic [9:0]  RST_VIS_H = 10'd192;
    localparam logic [15:0] RST_MAX   = 16'd0;
    localparam logic [12:0] RST_BUF_W = 13'd512;
    localparam logic [12:0] RST_BUF_H = 13'd256;
    localparam logic [2:0]  RST_STEP  = 3'd1;

    // Motion constants
    localparam logic [16:0] DISP_CAP   = 17'd64;
    localparam logic [16:0] FAST_MAG   = 17'd24;
    localparam logic [16:0] MID_MAG    = 17'd4;
    localparam logic [4:0]  MAX_SPEED  = 5'd5;
    localparam logic [3:0]  TILE_MASK  = 4'hF;

    typedef struct packed {
        logic               opcode;
        logic               follow;
        logic [15:0]        actor_x;
        logic [15:0]        actor_y;
        logic [10:0]        cursor_x;
        logic [10:0]        cursor_y;
        logic signed [15:0] set_x;
        logic signed [15:0] set_y;
    } t_req;

    typedef struct packed {
        logic [15:0] cam_x;
        logic [15:0] cam_y;
        logic [11:0] wrap_x;
        logic [11:0] wrap_y;
        logic        map_update;
    } t_res;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] value;
    } t_cfg;

endpackage

// ===== hw/rtl/scf_if.sv =====
interface scf_req_if;
    logic          valid;
    logic          ready;
    scf_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface scf_res_if;
    logic          valid;
    logic          ready;
    scf_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface scf_cfg_if;
    logic          valid;
    logic          ready;
    scf_pkg::t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/scroll_camera_follow.sv =====
// Scroll camera, one request per video frame.
// i_req carries a frame tick (move towards the actor/cursor target) or a
// set-position request; each accepted request yields exactly one result on
// o_res: camera x/y, plain and wrapped by the map buffer size, and map_update.
// i_cfg writes the seven registers by index and is always ready; write it
// only while no request is in flight. Index 7 is ignored.
// Both axes pass through one shared axis unit in turn: per axis the offset,
// the target, the speed lookup, the pixel steps (0 to 5), then the
// bit-serial remainder over the 16 position bits. A holding tick skips the
// target, and a set position goes from the offset state straight to the
// remainder. i_req is ready again once the result is registered, so a new
// request is taken only after the last one's result is in the output register.
// The result sits in an output register; if the receiver stalls, the next
// request is still taken and worked on, and waits only to be written out.
// Reset (synchronous, active low) restores the register defaults, puts the
// camera at the origin, the ramp phase at zero and drops any pending result.
module scroll_camera_follow (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scf_req_if.sink     i_req,
    scf_res_if.source   o_res,
    scf_cfg_if.sink     i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OFF,
        S_TGT,
        S_SPD,
        S_STEP,
        S_MOD,
        S_DONE
    } t_state;

    t_state        r_state;
    logic          r_axis;
    scf_pkg::t_req r_item;
    logic [15:0]   r_cam_x, r_cam_y;
    logic [2:0]    r_phase;
    logic signed [11:0] r_off;
    logic [15:0]   r_tgt;
    logic [2:0]    r_cnt;
    logic [12:0]   r_rem;
    logic [3:0]    r_bit;
    logic          r_flag;
    logic [11:0]   r_wrap_x;
    logic [11:0]   r_wrap_y;
    scf_pkg::t_res r_res;
    logic          r_res_valid;

    logic [9:0]    r_vis_w, r_vis_h;
    logic [15:0]   r_max_x, r_max_y;
    logic [12:0]   r_buf_w, r_buf_h;
    logic [2:0]    r_step;

    // Operands of the selected axis
    logic [15:0]        a_pos, a_hi, a_actor;
    logic [10:0]        a_cursor;
    logic [9:0]         a_vis;
    logic signed [15:0] a_set;
    logic [12:0]        a_buf;

    logic signed [11:0] d_diff, n_off;
    logic signed [17:0] tgt_sum;
    logic [15:0]        n_tgt_follow, n_tgt_hold, n_set_pos;
    logic [16:0]        mag;
    logic [2:0]         row;
    logic [4:0]         speed;
    logic [2:0]         n_cnt;
    logic               go_up, go_dn, on_tile;
    logic [13:0]        rem_sh, rem_nx;
    logic [11:0]        n_wrap;
    logic               load_res;

    assign a_pos    = r_axis ? r_cam_y : r_cam_x;
    assign a_hi     = r_axis ? r_max_y : r_max_x;
    assign a_actor  = r_axis ? r_item.actor_y : r_item.actor_x;
    assign a_cursor = r_axis ? r_item.cursor_y : r_item.cursor_x;
    assign a_vis    = r_axis ? r_vis_h : r_vis_w;
    assign a_set    = r_axis ? r_item.set_y : r_item.set_x;
    assign a_buf    = r_axis ? r_buf_h : r_buf_w;

    // Three-quarter offset: d - floor(d / 4)
    assign d_diff = signed'({1'b0, a_cursor}) - signed'({2'b00, a_vis});
    assign n_off  = d_diff - (d_diff >>> 2);

    assign tgt_sum = signed'({2'b00, a_actor}) + signed'({{6{r_off[11]}}, r_off});

    always_comb begin
        if (tgt_sum < 0) begin
            n_tgt_follow = '0;
        end else if (tgt_sum > signed'({2'b00, a_hi})) begin
            n_tgt_follow = a_hi;
        end else begin
            n_tgt_follow = tgt_sum[15:0];
        end
    end

    assign n_tgt_hold = (a_pos > a_hi) ? a_hi : a_pos;

    always_comb begin
        if (a_set < 0) begin
            n_set_pos = '0;
        end else if ({1'b0, a_set[14:0]} > a_hi) begin
            n_set_pos = a_hi;
        end else begin
            n_set_pos = {1'b0, a_set[14:0]};
        end
    end

    // Speed lookup from capped displacement and ramp phase
    assign mag = (r_tgt > a_pos) ? ({1'b0, r_tgt} - {1'b0, a_pos})
                                 : ({1'b0, a_pos} - {1'b0, r_tgt});

    always_comb begin
        if (mag >= scf_pkg::FAST_MAG) begin
            row = 3'd5;
        end else if (mag >= scf_pkg::MID_MAG) begin
            row = 3'd4;
        end else begin
            row = mag[2:0];
        end
    end

    always_comb begin
        case (row)
            3'd1:    speed = (r_phase[1] == 1'b0) ? {2'b00, r_step} : 5'd0;
            3'd2:    speed = (r_phase[1:0] != 2'b11) ? {2'b00, r_step} : 5'd0;
            3'd3:    speed = {2'b00, r_step};
            3'd4:    speed = {1'b0, r_step, 1'b0};
            3'd5:    speed = {r_step, 2'b00};
            default: speed = 5'd0;
        endcase
    end

    assign n_cnt = (speed > scf_pkg::MAX_SPEED) ? 3'd0 : speed[2:0];

    // Single-pixel step; the limit checks stop a step at 0 and max
    assign go_up   = (r_tgt > a_pos) && (a_pos < a_hi);
    assign go_dn   = (r_tgt < a_pos) && (a_pos != 16'd0);
    assign on_tile = (a_pos[3:0] & scf_pkg::TILE_MASK) == 4'h0;

    // Restoring remainder, one bit of the position per cycle
    assign rem_sh = {r_rem, a_pos[r_bit]};
    assign rem_nx = (rem_sh >= {1'b0, a_buf}) ? (rem_sh - {1'b0, a_buf}) : rem_sh;
    assign n_wrap = (a_buf == 13'd0) ? a_pos[11:0] : rem_nx[11:0];

    assign load_res = (r_state == S_DONE) && (!r_res_valid || o_res.ready);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis_w <= scf_pkg::RST_VIS_W;
            r_vis_h <= scf_pkg::RST_VIS_H;
            r_max_x <= scf_pkg::RST_MAX;
            r_max_y <= scf_pkg::RST_MAX;
            r_buf_w <= scf_pkg::RST_BUF_W;
            r_buf_h <= scf_pkg::RST_BUF_H;
            r_step  <= scf_pkg::RST_STEP;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                scf_pkg::REG_VIS_W: r_vis_w <= i_cfg.data.value[9:0];
                scf_pkg::REG_VIS_H: r_vis_h <= i_cfg.data.value[9:0];
                scf_pkg::REG_MAX_X: r_max_x <= i_cfg.data.value;
                scf_pkg::REG_MAX_Y: r_max_y <= i_cfg.data.value;
                scf_pkg::REG_BUF_W: r_buf_w <= i_cfg.data.value[12:0];
                scf_pkg::REG_BUF_H: r_buf_h <= i_cfg.data.value[12:0];
                scf_pkg::REG_STEP:  r_step  <= i_cfg.data.value[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_cam_x     <= '0;
            r_cam_y     <= '0;
            r_phase     <= '0;
            r_flag      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (load_res) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_item  <= i_req.data;
                        r_axis  <= 1'b0;
                        r_flag  <= 1'b0;
                        r_state <= S_OFF;
                    end
                end
                S_OFF: begin
                    r_rem <= '0;
                    r_bit <= 4'd15;
                    if (r_item.opcode == scf_pkg::OP_SET) begin
                        if (r_axis) begin
                            r_cam_y <= n_set_pos;
                        end else begin
                            r_cam_x <= n_set_pos;
                        end
                        r_state <= S_MOD;
                    end else if (r_item.follow) begin
                        r_off   <= n_off;
                        r_state <= S_TGT;
                    end else begin
                        r_tgt   <= n_tgt_hold;
                        r_state <= S_SPD;
                    end
                end
                S_TGT: begin
                    r_tgt   <= n_tgt_follow;
                    r_state <= S_SPD;
                end
                S_SPD: begin
                    r_cnt   <= n_cnt;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (r_cnt != 3'd0) begin
                        r_cnt <= r_cnt - 3'd1;
                        if ((go_up || go_dn) && on_tile) begin
                            r_flag <= 1'b1;
                        end
                        if (go_up || go_dn) begin
                            if (r_axis) begin
                                r_cam_y <= go_up ? a_pos + 16'd1 : a_pos - 16'd1;
                            end else begin
                                r_cam_x <= go_up ? a_pos + 16'd1 : a_pos - 16'd1;
                            end
                        end
                    end else begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_rem <= rem_nx[12:0];
                    r_bit <= r_bit - 4'd1;
                    if (r_bit == 4'd0) begin
                        if (r_axis) begin
                            r_wrap_y <= n_wrap;
                            r_state  <= S_DONE;
                        end else begin
                            r_wrap_x <= n_wrap;
                            r_axis   <= 1'b1;
                            r_state  <= S_OFF;
                        end
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (load_res) begin
                        r_res.cam_x      <= r_cam_x;
                        r_res.cam_y      <= r_cam_y;
                        r_res.wrap_x     <= r_wrap_x;
                        r_res.wrap_y     <= r_wrap_y;
                        r_res.map_update <= r_flag;
                        if (r_item.opcode == scf_pkg::OP_TICK) begin
                            r_phase <= r_phase + 3'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The running remainder stays below a nonzero modulus
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && a_buf != 13'd0) |-> ({1'b0, r_rem} < {1'b0, a_buf}))
        else $error("remainder not below modulus");

    // A step cycle moves the camera by at most one pixel on each axis
    a_step_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |=>
        (((r_cam_x - $past(r_cam_x)) == 16'd0) || ((r_cam_x - $past(r_cam_x)) == 16'd1)
         || (($past(r_cam_x) - r_cam_x) == 16'd1))
        && (((r_cam_y - $past(r_cam_y)) == 16'd0) || ((r_cam_y - $past(r_cam_y)) == 16'd1)
         || (($past(r_cam_y) - r_cam_y) == 16'd1)))
        else $error("camera moved more than one pixel in a step");

    // A set-position result never raises map_update
    a_set_no_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_res && r_item.opcode == scf_pkg::OP_SET) |=> !o_res.data.map_update)
        else $error("map_update raised on set position");

    // The step counter never exceeds the largest speed
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPD) |=> ({2'b00, r_cnt} <= scf_pkg::MAX_SPEED))
        else $error("step count out of range");

endmodule

// ===== sim/testbench.sv =====
module testbench;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 60;
    localparam int LONG_HOLD    = 400;
    localparam int PHASES       = 6;

    typedef struct packed {
        logic        flag;
        logic [15:0] pos;
    } t_axis;

    logic i_clk;
    logic i_rst_n;

    scf_req_if req_ch ();
    scf_res_if res_ch ();
    scf_cfg_if cfg_ch ();

    scroll_camera_follow DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Register mirror and camera state as the block should hold them
    logic [9:0]  vis_w, vis_h;
    logic [15:0] lim_x, lim_y;
    logic [12:0] buf_w, buf_h;
    logic [2:0]  step_s;
    logic [15:0] view_x, view_y;
    logic [2:0]  ramp;

    scf_pkg::t_req pending_reqs[$];
    scf_pkg::t_res expected_frames[$];

    int   n_issued, n_accepted, n_errors;
    int   n_ticks, n_sets, n_flags, n_cfg_writes;
    int   send_idle_pct, recv_idle_pct;
    int   hold_asked, hold_seen, hold_left;
    int   quiet_cycles;
    int   anchor_x, anchor_y;
    logic req_taken;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [15:0] clamp_pos(longint t, logic [15:0] hi);
        longint top;
        top = hi;
        if (t < 0) return 16'd0;
        if (t > top) return hi;
        return t[15:0];
    endfunction

    // Target is actor plus three quarters of the cursor offset
    function automatic logic [15:0] follow_target(logic [15:0] actor, logic [10:0] cursor,
                                                  logic [9:0] vis, logic [15:0] hi);
        longint a, c, v, d;
        a = actor;
        c = cursor;
        v = vis;
        d = c - v;
        return clamp_pos(a + d - (d >>> 2), hi);
    endfunction

    function automatic int step_speed(logic [15:0] mag, logic [2:0] ph);
        int s;
        int sp;
        s = step_s;
        if (mag >= scf_pkg::FAST_MAG)     sp = s * 4;
        else if (mag >= scf_pkg::MID_MAG) sp = s * 2;
        else if (mag == 16'd3)            sp = s;
        else if (mag == 16'd2)            sp = (ph[1:0] != 2'd3) ? s : 0;
        else if (mag == 16'd1)            sp = (ph[1:0] < 2'd2) ? s : 0;
        else                              sp = 0;
        return (sp > scf_pkg::MAX_SPEED) ? 0 : sp;
    endfunction

    function automatic t_axis step_axis(logic [15:0] pos, logic [15:0] tgt,
                                        logic [15:0] hi, logic [2:0] ph);
        t_axis r;
        logic [15:0] mag;
        int n;
        int k;
        r.flag = 1'b0;
        r.pos  = pos;
        mag = (tgt > pos) ? tgt - pos : pos - tgt;
        n = step_speed(mag, ph);
        for (k = 0; k < n; k++) begin
            // hold at 0 and at the limit; a pixel not taken raises nothing
            if (tgt > r.pos && r.pos < hi) begin
                if (r.pos[3:0] == 4'h0) r.flag = 1'b1;
                r.pos = r.pos + 16'd1;
            end else if (tgt < r.pos && r.pos != 16'd0) begin
                if (r.pos[3:0] == 4'h0) r.flag = 1'b1;
                r.pos = r.pos - 16'd1;
            end
        end
        return r;
    endfunction

    function automatic logic [11:0] wrap_pos(logic [15:0] pos, logic [12:0] size);
        logic [15:0] rem;
        if (size == 13'd0) return pos[11:0];
        rem = pos % size;
        return rem[11:0];
    endfunction

    function automatic scf_pkg::t_res next_view(scf_pkg::t_req r);
        scf_pkg::t_res o;
        t_axis mx, my;
        logic [15:0] tx, ty;
        longint sx, sy;
        o.map_update = 1'b0;
        if (r.opcode == scf_pkg::OP_SET) begin
            sx = $signed(r.set_x);
            sy = $signed(r.set_y);
            view_x = clamp_pos(sx, lim_x);
            view_y = clamp_pos(sy, lim_y);
        end else begin
            if (r.follow) begin
                tx = follow_target(r.actor_x, r.cursor_x, vis_w, lim_x);
                ty = follow_target(r.actor_y, r.cursor_y, vis_h, lim_y);
            end else begin
                tx = (view_x > lim_x) ? lim_x : view_x;
                ty = (view_y > lim_y) ? lim_y : view_y;
            end
            mx = step_axis(view_x, tx, lim_x, ramp);
            my = step_axis(view_y, ty, lim_y, ramp);
            view_x = mx.pos;
            view_y = my.pos;
            o.map_update = mx.flag | my.flag;
            ramp = ramp + 3'd1;
        end
        o.cam_x  = view_x;
        o.cam_y  = view_y;
        o.wrap_x = wrap_pos(view_x, buf_w);
        o.wrap_y = wrap_pos(view_y, buf_h);
        return o;
    endfunction

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    function automatic scf_pkg::t_req make_tick(logic follow, logic [15:0] ax,
                                                logic [15:0] ay, logic [10:0] cx,
                                                logic [10:0] cy);
        scf_pkg::t_req r;
        r.opcode   = scf_pkg::OP_TICK;
        r.follow   = follow;
        r.actor_x  = ax;
        r.actor_y  = ay;
        r.cursor_x = cx;
        r.cursor_y = cy;
        r.set_x    = 16'($urandom);
        r.set_y    = 16'($urandom);
        return r;
    endfunction

    function automatic scf_pkg::t_req make_set(logic signed [15:0] sx,
                                               logic signed [15:0] sy);
        scf_pkg::t_req r;
        r.opcode   = scf_pkg::OP_SET;
        r.follow   = 1'($urandom);
        r.actor_x  = 16'($urandom);
        r.actor_y  = 16'($urandom);
        r.cursor_x = 11'($urandom);
        r.cursor_y = 11'($urandom);
        r.set_x    = sx;
        r.set_y    = sy;
        return r;
    endfunction

    function automatic int drift(int a, logic [15:0] hi);
        int p;
        int top;
        p = $urandom_range(99);
        top = hi;
        if (p >= 90)
            a += $urandom_range(1) ? int'($urandom_range(80, 20)) : -int'($urandom_range(80, 20));
        else if (p >= 60)
            a += int'($urandom_range(6)) - 3;
        if (a < 0) a = 0;
        if (a > top) a = top;
        return a;
    endfunction

    // Mostly follow requests that hover near a slowly moving spot, so the
    // camera settles and the slow speed rows and ramp phases get exercised
    function automatic scf_pkg::t_req random_item();
        scf_pkg::t_req r;
        int pick;
        int ax, ay, cx, cy;
        pick = $urandom_range(99);
        anchor_x = drift(anchor_x, lim_x);
        anchor_y = drift(anchor_y, lim_y);
        if (pick < 6) begin
            if ($urandom_range(1)) begin
                r = make_set(16'($urandom), 16'($urandom));
            end else begin
                anchor_x = int'($urandom_range(lim_x));
                anchor_y = int'($urandom_range(lim_y));
                r = make_set(16'(anchor_x), 16'(anchor_y));
            end
        end else if (pick < 14) begin
            r = make_tick(1'b0, 16'($urandom), 16'($urandom), 11'($urandom), 11'($urandom));
        end else if (pick < 20) begin
            r = make_tick(1'($urandom), 16'($urandom), 16'($urandom), 11'($urandom),
                          11'($urandom));
        end else begin
            ax = anchor_x + int'($urandom_range(4)) - 2;
            ay = anchor_y + int'($urandom_range(4)) - 2;
            cx = int'(vis_w) + int'($urandom_range(6)) - 3;
            cy = int'(vis_h) + int'($urandom_range(6)) - 3;
            if (cx < 0) cx = 0;
            if (cy < 0) cy = 0;
            r = make_tick(1'b1, 16'(ax), 16'(ay), 11'(cx), 11'(cy));
        end
        return r;
    endfunction

    task automatic issue(scf_pkg::t_req r);
        pending_reqs.push_back(r);
        n_issued++;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (n_accepted != n_issued || expected_frames.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic put_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge i_clk);
        cfg_ch.data  <= {idx, val};
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk);
        while (!cfg_ch.ready);
    endtask

    task automatic configure(logic [15:0] vw, logic [15:0] vh, logic [15:0] mx,
                             logic [15:0] my, logic [15:0] bw, logic [15:0] bh,
                             logic [15:0] su);
        put_reg(scf_pkg::REG_VIS_W, vw);
        put_reg(scf_pkg::REG_VIS_H, vh);
        put_reg(scf_pkg::REG_MAX_X, mx);
        put_reg(scf_pkg::REG_MAX_Y, my);
        put_reg(scf_pkg::REG_BUF_W, bw);
        put_reg(scf_pkg::REG_BUF_H, bh);
        put_reg(scf_pkg::REG_STEP, su);
        put_reg(REG_UNUSED, 16'($urandom));
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic directed_requests();
        issue(make_set(16'sh8000, -16'sd1));
        issue(make_set(16'sh7FFF, 16'sh7FFF));
        // start on a tile boundary, then walk all eight ramp phases
        issue(make_set(16'sd16, 16'sd32));
        repeat (8) issue(make_tick(1'b1, 16'd46, 16'd34, 11'd256, 11'd192));
        issue(make_tick(1'b0, 16'($urandom), 16'($urandom), 11'($urandom), 11'($urandom)));
        issue(make_tick(1'b1, 16'd0, 16'd0, 11'd0, 11'd0));
        issue(make_tick(1'b1, 16'hFFFF, 16'hFFFF, 11'h7FF, 11'h7FF));
        // creep onto the limit from just below it
        issue(make_set(16'sd1998, 16'sd1497));
        repeat (3) issue(make_tick(1'b1, 16'hFFFF, 16'hFFFF, 11'h7FF, 11'h7FF));
        issue(make_set(16'sd0, 16'sd0));
        issue(make_tick(1'b1, 16'd0, 16'd0, 11'd256, 11'd192));
        issue(make_tick(1'b1, 16'd1000, 16'd900, 11'd256, 11'd192));
    endtask

    // Sender: advance to the next request once the current one is taken
    always @(posedge i_clk) req_taken <= req_ch.valid && req_ch.ready;

    always @(negedge i_clk) begin
        if (i_rst_n && (!req_ch.valid || req_taken)) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req_ch.data  <= pending_reqs.pop_front();
                req_ch.valid <= 1'b1;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : watch_results
        scf_pkg::t_res want;
        scf_pkg::t_res got;
        if (!i_rst_n) begin
            vis_w  = scf_pkg::RST_VIS_W;
            vis_h  = scf_pkg::RST_VIS_H;
            lim_x  = scf_pkg::RST_MAX;
            lim_y  = scf_pkg::RST_MAX;
            buf_w  = scf_pkg::RST_BUF_W;
            buf_h  = scf_pkg::RST_BUF_H;
            step_s = scf_pkg::RST_STEP;
            view_x = 16'd0;
            view_y = 16'd0;
            ramp   = 3'd0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                n_cfg_writes++;
                case (cfg_ch.data.index)
                    scf_pkg::REG_VIS_W: vis_w  = cfg_ch.data.value[9:0];
                    scf_pkg::REG_VIS_H: vis_h  = cfg_ch.data.value[9:0];
                    scf_pkg::REG_MAX_X: lim_x  = cfg_ch.data.value;
                    scf_pkg::REG_MAX_Y: lim_y  = cfg_ch.data.value;
                    scf_pkg::REG_BUF_W: buf_w  = cfg_ch.data.value[12:0];
                    scf_pkg::REG_BUF_H: buf_h  = cfg_ch.data.value[12:0];
                    scf_pkg::REG_STEP:  step_s = cfg_ch.data.value[2:0];
                    default: ;
                endcase
            end
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.data;
                if (expected_frames.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result: expected none, got %p", $time, got);
                end else begin
                    want = expected_frames.pop_front();
                    check_field("cam_x", want.cam_x, got.cam_x);
                    check_field("cam_y", want.cam_y, got.cam_y);
                    check_field("wrap_x", want.wrap_x, got.wrap_x);
                    check_field("wrap_y", want.wrap_y, got.wrap_y);
                    check_field("map_update", want.map_update, got.map_update);
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                want = next_view(req_ch.data);
                expected_frames.push_back(want);
                n_accepted++;
                if (req_ch.data.opcode == scf_pkg::OP_SET) n_sets++;
                else n_ticks++;
                if (want.map_update) n_flags++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_frames.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int ph;
        int k;
        int n;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        res_ch.ready  = 1'b0;
        i_rst_n       = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 88;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // a few requests against the reset register values
        issue(make_tick(1'b1, 16'd500, 16'd400, 11'd300, 11'd300));
        issue(make_set(16'sd100, 16'sd100));
        issue(make_tick(1'b0, 16'd0, 16'd0, 11'd0, 11'd0));
        drain();

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 37;
                recv_idle_pct = 88;
            end else if (ph < 4) begin
                send_idle_pct = 88;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0: configure(256, 192, 2000, 1500, 512, 256, 1);
                1: configure(1, 1023, 65535, 65535, 4096, 4096, 5);
                2: configure(1023, 1, 0, 40000, 0, 16'h1FFF, 0);
                3: configure(640, 480, 300, 200, 1, 4095, 2);
                4: configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom));
                default: configure(320, 240, 65535, 65535, 13, 4097, 7);
            endcase
            if (ph == 0) directed_requests();
            n = (ph == 2 || ph == 5) ? 130 : 240;
            for (k = 0; k < n / 2; k++) issue(random_item());
            // stall the output while requests keep coming, then let it all drain
            hold_asked++;
            drain();
            for (k = n / 2; k < n; k++) issue(random_item());
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_frames.size() != 0) begin
            n_errors++;
            $display("%0t: %0d results never arrived", $time, expected_frames.size());
        end
        $display("Ran %0d requests: %0d frame ticks, %0d set-position, %0d raising map_update.",
                 n_accepted, n_ticks, n_sets, n_flags);
        $display("%0d register writes over %0d settings, with swapped and no back-pressure.",
                 n_cfg_writes, PHASES);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
